// ----- src/apso_pkg.sv -----
// shared types and constants for the all-pairs shape overlap block
package apso_pkg;

   // collider kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BOX    = 2'd1;
   localparam logic [1:0] KIND_SPHERE = 2'd2;

   localparam int TAG_BITS   = 16;
   localparam int HIT_BITS   = TAG_BITS + 1;
   localparam int INDEX_BITS = 5;

   // one pair test takes a slot of phases 0 to PHASE_LAST
   localparam int PHASE_BITS = 3;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_REPORT
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic                  shift;
      logic [PHASE_BITS-1:0] phase;
   } cell_ctl_type;

endpackage

// ----- src/apso_req_if.sv -----
// request channel carrying one collider
interface apso_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   shape_kind;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] first_z;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic signed [COORD_BITS-1:0] second_z;
   logic signed [COORD_BITS-1:0] offset_x;
   logic signed [COORD_BITS-1:0] offset_y;
   logic signed [COORD_BITS-1:0] offset_z;
   logic [15:0]                  shape_tag;
   logic                         set_end;

   modport source(output valid, shape_kind, first_x, first_y, first_z, second_x, second_y,
                  second_z, offset_x, offset_y, offset_z, shape_tag, set_end,
                  input ready);
   modport sink(input valid, shape_kind, first_x, first_y, first_z, second_x, second_y,
                second_z, offset_x, offset_y, offset_z, shape_tag, set_end,
                output ready);
endinterface

// ----- src/apso_rsp_if.sv -----
// response channel carrying one per-collider hit report
interface apso_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  collider_index;
   logic        was_hit;
   logic [15:0] partner_tag;
   logic        report_end;

   modport source(output valid, collider_index, was_hit, partner_tag, report_end,
                  input ready);
   modport sink(input valid, collider_index, was_hit, partner_tag, report_end,
                output ready);
endinterface

// ----- src/all_pairs_shape_overlap.sv -----
// top level: all-pairs collider overlap over a chain of cells
// Usage: each request on req_ch loads one collider (kind, corners or center and
// radius, world offset, tag) into the next cell of the chain; offsets are added
// on load. Requests past MAX_SHAPES colliders are dropped. The request with
// set_end starts testing: req_ch.ready falls until the set has been reported.
// Testing injects one probe per collider into the head of the chain, one per
// slot; each cell tests the probe against its own collider during the slot,
// one axis per cycle, squaring the distance and the radius sum in two
// squarers. Testing lasts N+MAX_SHAPES slots for N loaded colliders, then N
// responses follow on rsp_ch in load order, one per cycle while rsp_ch.ready
// is high, the last flagged with report_end. A stalled receiver holds the
// response register and reporting waits; once the last response is
// registered, loading of the next set may start.
// Reset (synchronous, active high) empties the set and clears the handshake
// state; collider storage keeps stale data that is never read before written.
module all_pairs_shape_overlap #(
   parameter int MAX_SHAPES = 32,
   parameter int COORD_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   apso_req_if.sink   req_ch,
   apso_rsp_if.source rsp_ch
);
   localparam int VW  = COORD_BITS + 1;
   localparam int IW  = $clog2(MAX_SHAPES);
   localparam int NW  = $clog2(MAX_SHAPES + 1);
   localparam int SLW = $clog2(2 * MAX_SHAPES);
   localparam int HB  = apso_pkg::HIT_BITS;
   localparam int TB  = apso_pkg::TAG_BITS;
   localparam logic [NW-1:0]  FULL_COUNT = NW'(MAX_SHAPES);
   localparam logic [SLW-1:0] SLOT_BASE  = SLW'(MAX_SHAPES - 1);

   apso_pkg::state_type state_ff, state_in;
   logic [NW-1:0]  count_ff, count_in;
   logic [SLW-1:0] slot_ff, slot_in;
   logic [apso_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [NW-1:0]  rpt_ff, rpt_in;
   logic [HB-1:0]  res_ff [MAX_SHAPES];

   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     rsp_index_ff, rsp_index_in;
   logic [HB-1:0]  rsp_hit_ff, rsp_hit_in;
   logic           rsp_end_ff, rsp_end_in;

   logic req_fire, rsp_fire, store, load_out, hit_clear;
   apso_pkg::cell_ctl_type ctl;

   // load data with the world offset applied
   logic [1:0]         wr_kind;
   logic [2:0][VW-1:0] wr_lo, wr_hi;
   logic signed [COORD_BITS-1:0] f_in [3];
   logic signed [COORD_BITS-1:0] s_in [3];
   logic signed [COORD_BITS-1:0] o_in [3];

   // probe chain and per-cell views
   logic               p_valid [MAX_SHAPES+1];
   logic [IW-1:0]      p_index [MAX_SHAPES+1];
   logic [1:0]         p_kind  [MAX_SHAPES+1];
   logic [TB-1:0]      p_tag   [MAX_SHAPES+1];
   logic [2:0][VW-1:0] p_lo    [MAX_SHAPES+1];
   logic [2:0][VW-1:0] p_hi    [MAX_SHAPES+1];
   logic [HB-1:0]      p_hit   [MAX_SHAPES+1];
   logic [1:0]         c_kind  [MAX_SHAPES];
   logic [TB-1:0]      c_tag   [MAX_SHAPES];
   logic [2:0][VW-1:0] c_lo    [MAX_SHAPES];
   logic [2:0][VW-1:0] c_hi    [MAX_SHAPES];
   logic [HB-1:0]      c_hit   [MAX_SHAPES];
   logic [IW-1:0]      inj_sel, rpt_sel;

   assign f_in[0] = req_ch.first_x;
   assign f_in[1] = req_ch.first_y;
   assign f_in[2] = req_ch.first_z;
   assign s_in[0] = req_ch.second_x;
   assign s_in[1] = req_ch.second_y;
   assign s_in[2] = req_ch.second_z;
   assign o_in[0] = req_ch.offset_x;
   assign o_in[1] = req_ch.offset_y;
   assign o_in[2] = req_ch.offset_z;
   assign wr_kind = req_ch.shape_kind;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wr_lo[k] = VW'(f_in[k]) + VW'(o_in[k]);
         if (wr_kind == apso_pkg::KIND_SPHERE) begin
            wr_hi[k] = (k == 0) ? VW'(s_in[0]) : '0;
         end else begin
            wr_hi[k] = VW'(s_in[k]) + VW'(o_in[k]);
         end
      end
   end

   // probe injection at the head of the chain
   assign inj_sel    = slot_ff[IW-1:0];
   assign p_valid[0] = (state_ff == apso_pkg::ST_RUN) && (SLW'(count_ff) > slot_ff);
   assign p_index[0] = inj_sel;
   assign p_kind[0]  = c_kind[inj_sel];
   assign p_tag[0]   = c_tag[inj_sel];
   assign p_lo[0]    = c_lo[inj_sel];
   assign p_hi[0]    = c_hi[inj_sel];
   assign p_hit[0]   = '0;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;
   assign store     = req_fire && (count_ff < FULL_COUNT);
   assign hit_clear = req_fire && req_ch.set_end;
   assign ctl.phase = phase_ff;
   assign ctl.shift = (state_ff == apso_pkg::ST_RUN) && (phase_ff == apso_pkg::PHASE_LAST);

   // cell chain
   for (genvar g = 0; g < MAX_SHAPES; g++) begin : g_cell
      apso_cell #(
         .COORD_BITS(COORD_BITS),
         .MAX_SHAPES(MAX_SHAPES),
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .loaded   (count_ff),
         .wr_en    (store && (count_ff == NW'(g))),
         .hit_clear(hit_clear),
         .wr_kind  (wr_kind),
         .wr_tag   (req_ch.shape_tag),
         .wr_lo    (wr_lo),
         .wr_hi    (wr_hi),
         .pi_valid (p_valid[g]),
         .pi_index (p_index[g]),
         .pi_kind  (p_kind[g]),
         .pi_tag   (p_tag[g]),
         .pi_lo    (p_lo[g]),
         .pi_hi    (p_hi[g]),
         .pi_hit   (p_hit[g]),
         .po_valid (p_valid[g+1]),
         .po_index (p_index[g+1]),
         .po_kind  (p_kind[g+1]),
         .po_tag   (p_tag[g+1]),
         .po_lo    (p_lo[g+1]),
         .po_hi    (p_hi[g+1]),
         .po_hit   (p_hit[g+1]),
         .own_kind (c_kind[g]),
         .own_tag  (c_tag[g]),
         .own_lo   (c_lo[g]),
         .own_hi   (c_hi[g]),
         .own_hit  (c_hit[g])
      );
   end

   // probes leaving the chain carry the hits with later colliders
   always_ff @(posedge clock) begin
      if (ctl.shift && p_valid[MAX_SHAPES]) begin
         res_ff[p_index[MAX_SHAPES]] <= p_hit[MAX_SHAPES];
      end
   end

   // sequencer
   assign rpt_sel  = rpt_ff[IW-1:0];
   assign load_out = (state_ff == apso_pkg::ST_REPORT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      phase_in     = phase_ff;
      rpt_in       = rpt_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_end_in   = rsp_end_ff;
      req_ch.ready = 1'b0;
      case (state_ff)
         apso_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (store) begin
               count_in = count_ff + NW'(1);
            end
            if (hit_clear) begin
               state_in = apso_pkg::ST_RUN;
               slot_in  = '0;
               phase_in = '0;
            end
         end
         apso_pkg::ST_RUN: begin
            if (phase_ff == apso_pkg::PHASE_LAST) begin
               phase_in = '0;
               slot_in  = slot_ff + SLW'(1);
               if (slot_ff == SLW'(count_ff) + SLOT_BASE) begin
                  state_in = apso_pkg::ST_REPORT;
                  rpt_in   = '0;
               end
            end else begin
               phase_in = phase_ff + apso_pkg::PHASE_BITS'(1);
            end
         end
         apso_pkg::ST_REPORT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 5'(rpt_ff);
               rsp_hit_in   = res_ff[rpt_sel][HB-1] ? res_ff[rpt_sel] : c_hit[rpt_sel];
               rsp_end_in   = (rpt_ff + NW'(1)) == count_ff;
               rpt_in       = rpt_ff + NW'(1);
               if ((rpt_ff + NW'(1)) == count_ff) begin
                  state_in = apso_pkg::ST_IDLE;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = apso_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apso_pkg::ST_IDLE;
         count_ff     <= '0;
         slot_ff      <= '0;
         phase_ff     <= '0;
         rpt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         rpt_ff       <= rpt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.collider_index = rsp_index_ff;
   assign rsp_ch.was_hit        = rsp_hit_ff[HB-1];
   assign rsp_ch.partner_tag    = rsp_hit_ff[TB-1:0];
   assign rsp_ch.report_end     = rsp_end_ff;
endmodule

// ----- src/apso_cell.sv -----
// one chain cell: holds a collider and tests it against the probe passing through
module apso_cell #(
   parameter int COORD_BITS = 16,
   parameter int MAX_SHAPES = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  apso_pkg::cell_ctl_type                ctl,
   input  logic [$clog2(MAX_SHAPES+1)-1:0]       loaded,
   input  logic                                  wr_en,
   input  logic                                  hit_clear,
   input  logic [1:0]                            wr_kind,
   input  logic [apso_pkg::TAG_BITS-1:0]         wr_tag,
   input  logic [2:0][COORD_BITS:0]              wr_lo,
   input  logic [2:0][COORD_BITS:0]              wr_hi,
   input  logic                                  pi_valid,
   input  logic [$clog2(MAX_SHAPES)-1:0]         pi_index,
   input  logic [1:0]                            pi_kind,
   input  logic [apso_pkg::TAG_BITS-1:0]         pi_tag,
   input  logic [2:0][COORD_BITS:0]              pi_lo,
   input  logic [2:0][COORD_BITS:0]              pi_hi,
   input  logic [apso_pkg::HIT_BITS-1:0]         pi_hit,
   output logic                                  po_valid,
   output logic [$clog2(MAX_SHAPES)-1:0]         po_index,
   output logic [1:0]                            po_kind,
   output logic [apso_pkg::TAG_BITS-1:0]         po_tag,
   output logic [2:0][COORD_BITS:0]              po_lo,
   output logic [2:0][COORD_BITS:0]              po_hi,
   output logic [apso_pkg::HIT_BITS-1:0]         po_hit,
   output logic [1:0]                            own_kind,
   output logic [apso_pkg::TAG_BITS-1:0]         own_tag,
   output logic [2:0][COORD_BITS:0]              own_lo,
   output logic [2:0][COORD_BITS:0]              own_hi,
   output logic [apso_pkg::HIT_BITS-1:0]         own_hit
);
   localparam int VW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 2;
   localparam int SW = 2 * DW;
   localparam int AW = SW + 2;
   localparam int IW = $clog2(MAX_SHAPES);
   localparam int NW = $clog2(MAX_SHAPES + 1);
   localparam logic [NW-1:0] CI = NW'(CELL_INDEX);

   // stored collider
   logic [1:0]                    kind_ff;
   logic [apso_pkg::TAG_BITS-1:0] tag_ff;
   logic [2:0][VW-1:0]            lo_ff, hi_ff;
   logic [apso_pkg::HIT_BITS-1:0] hit_ff;

   // probe currently in this cell
   logic                          pv_ff;
   logic [IW-1:0]                 pidx_ff;
   logic [1:0]                    pk_ff;
   logic [apso_pkg::TAG_BITS-1:0] pt_ff;
   logic [2:0][VW-1:0]            plo_ff, phi_ff;
   logic [apso_pkg::HIT_BITS-1:0] phit_ff;

   // test datapath
   logic signed [DW-1:0] d_ff, rs_ff;
   logic [SW-1:0]        sq_ff, rr_ff;
   logic [AW-1:0]        acc_ff;
   logic                 slab_ff;

   logic [1:0]           axis;
   logic                 p_box, p_sph, c_box, c_sph, both_box, both_sph;
   logic signed [VW-1:0] pl, ph, cl, ch, box_lo, box_hi, ctr, q;
   logic signed [DW-1:0] d_in, rs_in;
   logic signed [SW-1:0] sq_in, rr_in;
   logic                 slab_in, test_ok, overlap, hit_now;

   always_comb begin
      case (ctl.phase)
         3'd0: axis = 2'd0;
         3'd1: axis = 2'd1;
         default: axis = 2'd2;
      endcase
      p_box    = pk_ff == apso_pkg::KIND_BOX;
      p_sph    = pk_ff == apso_pkg::KIND_SPHERE;
      c_box    = kind_ff == apso_pkg::KIND_BOX;
      c_sph    = kind_ff == apso_pkg::KIND_SPHERE;
      both_box = p_box && c_box;
      both_sph = p_sph && c_sph;
      pl = $signed(plo_ff[axis]);
      ph = $signed(phi_ff[axis]);
      cl = $signed(lo_ff[axis]);
      ch = $signed(hi_ff[axis]);
      // box and sphere center for the mixed case
      box_lo = p_box ? pl : cl;
      box_hi = p_box ? ph : ch;
      ctr    = p_box ? cl : pl;
      if (ctr < box_lo) begin
         q = box_lo;
      end else if (ctr > box_hi) begin
         q = box_hi;
      end else begin
         q = ctr;
      end
      d_in    = both_sph ? (DW'(pl) - DW'(cl)) : (DW'(q) - DW'(ctr));
      slab_in = (pl <= ch) && (ph >= cl);
      if (both_sph) begin
         rs_in = DW'($signed(phi_ff[0])) + DW'($signed(hi_ff[0]));
      end else begin
         rs_in = p_box ? DW'($signed(hi_ff[0])) : DW'($signed(phi_ff[0]));
      end
      // full-width squares
      sq_in = SW'(d_ff) * SW'(d_ff);
      rr_in = SW'(rs_ff) * SW'(rs_ff);
      test_ok = pv_ff && (NW'(pidx_ff) < CI) && (CI < loaded) &&
                (p_box || p_sph) && (c_box || c_sph);
      overlap = both_box ? slab_ff : (!rs_ff[DW-1] && (acc_ff <= AW'(rr_ff)));
      hit_now = ctl.shift && test_ok && overlap;
   end

   // collider storage and hit record
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kind_ff <= wr_kind;
         tag_ff  <= wr_tag;
         lo_ff   <= wr_lo;
         hi_ff   <= wr_hi;
      end
      if (hit_clear) begin
         hit_ff <= '0;
      end else if (hit_now) begin
         hit_ff <= {1'b1, pt_ff};
      end
   end

   // squared distance pipeline, one axis per cycle
   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      sq_ff <= $unsigned(sq_in);
      rs_ff <= rs_in;
      rr_ff <= $unsigned(rr_in);
      case (ctl.phase)
         3'd0: slab_ff <= slab_in;
         3'd1, 3'd2: slab_ff <= slab_ff && slab_in;
         default: slab_ff <= slab_ff;
      endcase
      case (ctl.phase)
         3'd2: acc_ff <= AW'(sq_ff);
         3'd3, 3'd4: acc_ff <= acc_ff + AW'(sq_ff);
         default: acc_ff <= acc_ff;
      endcase
   end

   // probe advance
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (ctl.shift) begin
         pv_ff <= pi_valid;
      end
      if (ctl.shift) begin
         pidx_ff <= pi_index;
         pk_ff   <= pi_kind;
         pt_ff   <= pi_tag;
         plo_ff  <= pi_lo;
         phi_ff  <= pi_hi;
         phit_ff <= pi_hit;
      end
   end

   assign po_valid = pv_ff;
   assign po_index = pidx_ff;
   assign po_kind  = pk_ff;
   assign po_tag   = pt_ff;
   assign po_lo    = plo_ff;
   assign po_hi    = phi_ff;
   assign po_hit   = hit_now ? {1'b1, tag_ff} : phit_ff;
   assign own_kind = kind_ff;
   assign own_tag  = tag_ff;
   assign own_lo   = lo_ff;
   assign own_hi   = hi_ff;
   assign own_hit  = hit_ff;
endmodule

// ----- tb/apso_checker.sv -----
// checker for the all-pairs shape overlap block: predicts hit reports and compares
module apso_checker #(
   parameter int MAX_SHAPES = 32
) (
   input  logic clock,
   input  logic reset,
   apso_req_if  req_ch,
   apso_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending_reports
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [apso_pkg::INDEX_BITS-1:0] index;
      logic                            hit;
      logic [apso_pkg::TAG_BITS-1:0]   tag;
      logic                            last;
   } hit_report_type;

   // world-space collider copy
   logic [1:0]                    kind_mem  [MAX_SHAPES];
   logic [apso_pkg::TAG_BITS-1:0] tag_mem   [MAX_SHAPES];
   longint                        lo_mem    [MAX_SHAPES][3];
   longint                        hi_mem    [MAX_SHAPES][3];
   logic [apso_pkg::HIT_BITS-1:0] hit_mem   [MAX_SHAPES];
   int                            shape_count;
   hit_report_type                expected_reports[$];

   assign pending_reports = expected_reports.size();

   function automatic bit boxes_touch(int a, int b);
      for (int k = 0; k < 3; k++)
         if (!(lo_mem[a][k] <= hi_mem[b][k] && hi_mem[a][k] >= lo_mem[b][k])) return 0;
      return 1;
   endfunction

   function automatic bit spheres_touch(int a, int b);
      longint dist2;
      longint rsum;
      longint d;
      dist2 = 0;
      rsum = hi_mem[a][0] + hi_mem[b][0];
      if (rsum < 0) return 0;
      for (int k = 0; k < 3; k++) begin
         d = lo_mem[a][k] - lo_mem[b][k];
         dist2 += d * d;
      end
      return dist2 <= rsum * rsum;
   endfunction

   function automatic bit box_meets_sphere(int bx, int sp);
      longint dist2;
      longint rad;
      longint c;
      longint p;
      dist2 = 0;
      rad = hi_mem[sp][0];
      if (rad < 0) return 0;
      for (int k = 0; k < 3; k++) begin
         c = lo_mem[sp][k];
         // clamp: the lower bound is tested first, so on inverted boxes it wins only below it
         if (c < lo_mem[bx][k]) p = lo_mem[bx][k];
         else if (c > hi_mem[bx][k]) p = hi_mem[bx][k];
         else p = c;
         dist2 += (p - c) * (p - c);
      end
      return dist2 <= rad * rad;
   endfunction

   function automatic bit pair_touches(int a, int b);
      if (kind_mem[a] == apso_pkg::KIND_BOX && kind_mem[b] == apso_pkg::KIND_BOX)
         return boxes_touch(a, b);
      if (kind_mem[a] == apso_pkg::KIND_SPHERE && kind_mem[b] == apso_pkg::KIND_SPHERE)
         return spheres_touch(a, b);
      if (kind_mem[a] == apso_pkg::KIND_BOX && kind_mem[b] == apso_pkg::KIND_SPHERE)
         return box_meets_sphere(a, b);
      if (kind_mem[a] == apso_pkg::KIND_SPHERE && kind_mem[b] == apso_pkg::KIND_BOX)
         return box_meets_sphere(b, a);
      return 0;
   endfunction

   function automatic bit is_live(int i);
      return kind_mem[i] == apso_pkg::KIND_BOX || kind_mem[i] == apso_pkg::KIND_SPHERE;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // load one collider and resolve the set on its end marker
   task automatic absorb_collider();
      hit_report_type r;
      longint off[3];
      longint first[3];
      longint second[3];
      off    = '{req_ch.offset_x, req_ch.offset_y, req_ch.offset_z};
      first  = '{req_ch.first_x, req_ch.first_y, req_ch.first_z};
      second = '{req_ch.second_x, req_ch.second_y, req_ch.second_z};
      if (shape_count < MAX_SHAPES) begin
         kind_mem[shape_count] = req_ch.shape_kind;
         tag_mem[shape_count]  = req_ch.shape_tag;
         for (int k = 0; k < 3; k++) begin
            lo_mem[shape_count][k] = first[k] + off[k];
            if (req_ch.shape_kind == apso_pkg::KIND_SPHERE)
               hi_mem[shape_count][k] = (k == 0) ? second[0] : 0;
            else
               hi_mem[shape_count][k] = second[k] + off[k];
         end
         shape_count++;
      end
      if (!req_ch.set_end) return;
      for (int i = 0; i < shape_count; i++) hit_mem[i] = '0;
      for (int i = 0; i < shape_count; i++) begin
         if (!is_live(i)) continue;
         for (int j = i + 1; j < shape_count; j++) begin
            if (is_live(j) && pair_touches(i, j)) begin
               hit_mem[i] = {1'b1, tag_mem[j]};
               hit_mem[j] = {1'b1, tag_mem[i]};
            end
         end
      end
      for (int i = 0; i < shape_count; i++) begin
         r.index = i[apso_pkg::INDEX_BITS-1:0];
         r.hit   = hit_mem[i][apso_pkg::TAG_BITS];
         r.tag   = hit_mem[i][apso_pkg::TAG_BITS-1:0];
         r.last  = (i + 1 == shape_count);
         expected_reports = {expected_reports, r};
      end
      shape_count = 0;
   endtask

   task automatic compare_report();
      hit_report_type r;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected report index", rsp_ch.collider_index, -1);
         return;
      end
      r = expected_reports.pop_front();
      if (rsp_ch.collider_index !== r.index)
         report_mismatch("collider_index", rsp_ch.collider_index, r.index);
      if (rsp_ch.was_hit !== r.hit) report_mismatch("was_hit", rsp_ch.was_hit, r.hit);
      if (rsp_ch.partner_tag !== r.tag)
         report_mismatch("partner_tag", rsp_ch.partner_tag, r.tag);
      if (rsp_ch.report_end !== r.last)
         report_mismatch("report_end", rsp_ch.report_end, r.last);
   endtask

   initial begin
      fail_count  = 0;
      shape_count = 0;
   end

   // sample both channels at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) absorb_collider();
         if (rsp_ch.valid && rsp_ch.ready) compare_report();
      end
   end
endmodule

// ----- tb/testbench.sv -----
// stimulus and verdict for the all-pairs shape overlap block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SHAPES = 32;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_reports;
   bit   sender_done;

   apso_req_if #(.COORD_BITS(16)) req_ch ();
   apso_rsp_if                    rsp_ch ();

   all_pairs_shape_overlap #(.MAX_SHAPES(MAX_SHAPES), .COORD_BITS(16)) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   apso_checker #(.MAX_SHAPES(MAX_SHAPES)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .fail_count     (fail_count),
      .pending_reports(pending_reports)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random coordinate, often near the extremes
   function automatic logic [15:0] coord();
      case ($urandom_range(0, 5))
         0: return 16'(32'h8000 + $urandom_range(0, 3));
         1: return 16'(32'h7fff - $urandom_range(0, 3));
         2: return 16'($urandom());
         default: return 16'($urandom_range(0, 400) - 200);
      endcase
   endfunction

   // send one collider request
   task automatic send_collider(logic [1:0] kind, logic [15:0] f[3], logic [15:0] s[3],
                                logic [15:0] o[3], logic [15:0] tag, logic last);
      int pause;
      pause = gap_length();
      if (pause > 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.shape_kind <= kind;
      req_ch.first_x    <= f[0];
      req_ch.first_y    <= f[1];
      req_ch.first_z    <= f[2];
      req_ch.second_x   <= s[0];
      req_ch.second_y   <= s[1];
      req_ch.second_z   <= s[2];
      req_ch.offset_x   <= o[0];
      req_ch.offset_y   <= o[1];
      req_ch.offset_z   <= o[2];
      req_ch.shape_tag  <= tag;
      req_ch.set_end    <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(logic last, bit wild);
      logic [15:0] f[3];
      logic [15:0] s[3];
      logic [15:0] o[3];
      logic [1:0]  kind;
      for (int k = 0; k < 3; k++) begin
         if (wild) begin
            f[k] = coord();
            s[k] = coord();
            o[k] = coord();
         end else begin
            f[k] = 16'($urandom_range(0, 300) - 150);
            s[k] = 16'(32'(f[k]) + $urandom_range(0, 120) - 10);
            o[k] = 16'($urandom_range(0, 60) - 30);
         end
      end
      kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
             (($urandom_range(0, 1) == 1) ? apso_pkg::KIND_BOX : apso_pkg::KIND_SPHERE);
      if (kind == apso_pkg::KIND_SPHERE && !wild) s[0] = 16'($urandom_range(0, 100));
      send_collider(kind, f, s, o, 16'($urandom()), last);
   endtask

   // receiver stalls
   initial begin
      int pause;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         pause = gap_length();
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // stimulus
   initial begin
      logic [15:0] lo3[3];
      logic [15:0] hi3[3];
      logic [15:0] zero3[3];
      logic [15:0] big3[3];
      int          set_size;
      req_ch.valid = 1'b0;
      req_ch.shape_kind = apso_pkg::KIND_NONE;
      {req_ch.first_x, req_ch.first_y, req_ch.first_z} = '0;
      {req_ch.second_x, req_ch.second_y, req_ch.second_z} = '0;
      {req_ch.offset_x, req_ch.offset_y, req_ch.offset_z} = '0;
      req_ch.shape_tag = '0;
      req_ch.set_end = 1'b0;
      sender_done = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      zero3 = '{16'h0, 16'h0, 16'h0};
      big3  = '{16'h7fff, 16'h7fff, 16'h7fff};
      lo3   = '{16'h8000, 16'h8000, 16'h8000};
      hi3   = '{16'hffff, 16'hffff, 16'hffff};
      // touching boxes, touching spheres, unknown kinds
      send_collider(apso_pkg::KIND_BOX, zero3, '{16'h10, 16'h10, 16'h10}, zero3, 16'h1111,
                    1'b0);
      send_collider(apso_pkg::KIND_BOX, '{16'h10, 16'h10, 16'h10}, '{16'h20, 16'h20, 16'h20},
                    zero3, 16'h2222, 1'b0);
      send_collider(apso_pkg::KIND_SPHERE, '{16'h28, 16'h0, 16'h0}, '{16'h8, 16'h0, 16'h0},
                    zero3, 16'hffff, 1'b0);
      send_collider(apso_pkg::KIND_SPHERE, '{16'h38, 16'h0, 16'h0}, '{16'h8, 16'h0, 16'h0},
                    zero3, 16'h0001, 1'b0);
      send_collider(2'd3, zero3, big3, zero3, 16'h3333, 1'b0);
      send_collider(apso_pkg::KIND_NONE, zero3, big3, zero3, 16'h4444, 1'b0);
      // negative radii: sum negative, and a sphere with negative radius in a box
      send_collider(apso_pkg::KIND_SPHERE, zero3, '{16'hfff0, 16'h0, 16'h0}, zero3, 16'h5555,
                    1'b0);
      send_collider(apso_pkg::KIND_SPHERE, zero3, '{16'h0008, 16'h0, 16'h0}, zero3, 16'h6666,
                    1'b0);
      // inverted box and extreme offsets
      send_collider(apso_pkg::KIND_BOX, big3, lo3, big3, 16'h7777, 1'b0);
      send_collider(apso_pkg::KIND_BOX, lo3, big3, lo3, 16'h8888, 1'b0);
      send_collider(apso_pkg::KIND_SPHERE, big3, big3, big3, 16'h9999, 1'b0);
      send_collider(apso_pkg::KIND_SPHERE, lo3, '{16'h8000, 16'h0, 16'h0}, lo3, 16'haaaa,
                    1'b0);
      send_collider(apso_pkg::KIND_BOX, hi3, hi3, hi3, 16'h0000, 1'b1);
      // single-collider set
      send_collider(apso_pkg::KIND_BOX, zero3, zero3, zero3, 16'hbeef, 1'b1);
      // oversized set: extra items dropped, final one carries set_end
      for (int i = 0; i < MAX_SHAPES + 2; i++) send_random(i == MAX_SHAPES + 1, 1'b0);

      // random sets, mostly small, occasionally full
      for (int n = 0; n < 100; n += set_size) begin
         set_size = ($urandom_range(0, 9) == 0) ? MAX_SHAPES : $urandom_range(1, 8);
         for (int i = 0; i < set_size; i++)
            send_random(i == set_size - 1, $urandom_range(0, 4) == 0);
      end
      req_ch.valid <= 1'b0;
      sender_done = 1;
   end

   // verdict
   initial begin
      wait (sender_done);
      repeat (2) @(posedge clock);
      while (pending_reports != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
